FILE: hw/rtl/sott_pkg.sv
// Shared types and constants of the stop order trigger table.
package sott_pkg;

    // Default number of table entries.
    localparam int ENTRIES_DEF = 16;

    // Tick value after reset.
    localparam logic [15:0] TICK_RESET = 16'd1;

    // Request operation codes; the fourth code is ignored.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result status codes.
    localparam logic STATUS_FIRED   = 1'b0;
    localparam logic STATUS_DROPPED = 1'b1;

    // One request as it arrives on the input ports.
    typedef struct packed {
        logic [1:0]         op;
        logic [15:0]        order_id;
        logic signed [31:0] order_price;
        logic               is_sell;
        logic [7:0]         cut_slip;
        logic [15:0]        counter_id;
        logic signed [31:0] close_price;
    } t_req;

    // One result as it leaves on the output ports.
    typedef struct packed {
        logic               status;
        logic [15:0]        fired_id;
        logic signed [31:0] fired_price;
        logic               fired_sell;
    } t_res;

    // One stored order, as held in the entry memory.
    typedef struct packed {
        logic [15:0]        id;
        logic signed [31:0] price;
        logic               sell;
        logic [7:0]         slip;
        logic [15:0]        counter;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch a new request and rewind the scan
        logic scan_go;  // step the scan through the entry memory
        logic cscan;    // the scan deletes the counter order
        logic commit;   // apply the outcome of the first scan
        logic fire;     // build the slipped result of a triggered order
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;  // every entry has been read and evaluated
        logic hit;        // a price tick found a triggered order
    } t_dp_sts;

endpackage

FILE: hw/rtl/sott_ram.sv
// Generic single write port, single read port RAM with registered read data.
module sott_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/sott_ctrl.sv
// Controller state machine of the stop order trigger table.
module sott_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  sott_pkg::t_dp_sts i_sts,
    output sott_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_CSCAN,
        S_FIRE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = i_sts.hit ? S_CSCAN : S_IDLE;
            end
            S_CSCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and the registered busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd.load    = (r_state == S_IDLE) && i_start;
        o_cmd.scan_go = (r_state == S_SCAN) || (r_state == S_CSCAN);
        o_cmd.cscan   = (r_state == S_CSCAN);
        o_cmd.commit  = (r_state == S_COMMIT);
        o_cmd.fire    = (r_state == S_FIRE);
    end

    assign o_busy = r_busy;

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> r_busy)
        else $error("request accepted but block not busy afterwards");

    // A result is only built straight after the counter order scan.
    a_fire_after_cscan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fire |-> $past(r_state) == S_CSCAN)
        else $error("fire command outside the counter scan sequence");

endmodule

FILE: hw/rtl/sott_dp.sv
// Datapath of the stop order trigger table: entry store, scan, slip and result.
module sott_dp #(
    parameter int ENTRIES = sott_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  sott_pkg::t_req    i_req,
    input  sott_pkg::t_dp_cmd i_cmd,
    output sott_pkg::t_dp_sts o_sts,
    output sott_pkg::t_res    o_res,
    output logic              o_res_strobe
);

    localparam int AW = $clog2(ENTRIES);
    localparam int EW = $bits(sott_pkg::t_entry);
    localparam logic [AW:0] LAST_CNT = (AW + 1)'(ENTRIES);

    // Configuration and the latched request.
    logic [15:0]      r_tick;
    sott_pkg::t_req   r_req;

    // Valid bit of each entry.
    logic [ENTRIES-1:0] r_valid;

    // Scan address counter and the read pipeline.
    logic [AW:0]   r_cnt;
    logic          r_rd_vld;
    logic [AW-1:0] r_rd_idx;
    logic          issue;

    // Findings of the first scan.
    logic             r_match_found;
    logic [AW-1:0]    r_match_slot;
    logic             r_free_found;
    logic [AW-1:0]    r_free_slot;
    logic             r_hit;
    logic [AW-1:0]    r_best_slot;
    sott_pkg::t_entry r_best;

    // Slip product and result register.
    logic [23:0]    r_prod;
    sott_pkg::t_res r_res;
    logic           r_stb;

    // Memory ports.
    logic             wr_en;
    logic [AW-1:0]    wr_slot;
    sott_pkg::t_entry wr_entry;
    logic [EW-1:0]    rd_data;
    sott_pkg::t_entry rd_entry;

    // Per-entry compares on the word just read.
    logic ent_valid;
    logic id_match;
    logic cnt_match;
    logic price_match;
    logic drop;

    // Slipped and saturated price.
    logic signed [33:0] base;
    logic signed [33:0] delta;
    logic signed [33:0] sum;
    logic signed [31:0] sat_price;

    sott_ram #(
        .WIDTH (EW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_slot),
        .i_wr_data (wr_entry),
        .i_rd_en   (issue),
        .i_rd_addr (r_cnt[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_entry = sott_pkg::t_entry'(rd_data);
    assign issue    = i_cmd.scan_go && (r_cnt != LAST_CNT);

    // Compares of the entry returned by the memory.
    always_comb begin
        ent_valid   = r_valid[r_rd_idx];
        id_match    = ent_valid && (rd_entry.id == r_req.order_id);
        cnt_match   = ent_valid && (rd_entry.id == r_best.counter);
        price_match = ent_valid && (rd_entry.price == r_req.close_price)
                      && (!r_hit || (rd_entry.id < r_best.id));
    end

    // An add with neither a known id nor a free slot is dropped.
    assign drop = (r_req.op == sott_pkg::OP_ADD) && !r_match_found && !r_free_found;

    // Write of an added order.
    always_comb begin
        wr_en            = i_cmd.commit && (r_req.op == sott_pkg::OP_ADD) && !drop;
        wr_slot          = r_match_found ? r_match_slot : r_free_slot;
        wr_entry.id      = r_req.order_id;
        wr_entry.price   = r_req.order_price;
        wr_entry.sell    = r_req.is_sell;
        wr_entry.slip    = r_req.cut_slip;
        wr_entry.counter = r_req.counter_id;
    end

    // Price moved by the slip, clamped to the signed 32-bit range.
    always_comb begin
        base  = 34'(r_best.price);
        delta = $signed({10'b0, r_prod});
        sum   = r_best.sell ? (base - delta) : (base + delta);
        if ((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111)) begin
            sat_price = sum[31:0];
        end else if (sum[33]) begin
            sat_price = {1'b1, 31'b0};
        end else begin
            sat_price = {1'b0, {31{1'b1}}};
        end
    end

    // Control registers: configuration, valid bits, scan and strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick        <= sott_pkg::TICK_RESET;
            r_valid       <= '0;
            r_cnt         <= '0;
            r_rd_vld      <= 1'b0;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
            r_hit         <= 1'b0;
            r_stb         <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tick <= i_cfg_wr_data;
            end

            r_rd_vld <= issue;
            r_stb    <= (i_cmd.commit && drop) || i_cmd.fire;

            if (i_cmd.load || i_cmd.commit) begin
                r_cnt <= '0;
            end else if (issue) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (i_cmd.load) begin
                r_match_found <= 1'b0;
                r_free_found  <= 1'b0;
                r_hit         <= 1'b0;
            end else if (r_rd_vld && !i_cmd.cscan) begin
                // First scan: lowest slot wins for id and free, lowest id for price.
                if (id_match && !r_match_found) begin
                    r_match_found <= 1'b1;
                end
                if (!ent_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
                if (price_match && (r_req.op == sott_pkg::OP_TICK)) begin
                    r_hit <= 1'b1;
                end
            end

            // Valid bit updates at commit and during the counter scan.
            if (i_cmd.commit) begin
                if (wr_en) begin
                    r_valid[wr_slot] <= 1'b1;
                end
                if ((r_req.op == sott_pkg::OP_REMOVE) && r_match_found) begin
                    r_valid[r_match_slot] <= 1'b0;
                end
                if (r_hit) begin
                    r_valid[r_best_slot] <= 1'b0;
                end
            end else if (r_rd_vld && i_cmd.cscan && cnt_match) begin
                r_valid[r_rd_idx] <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (issue) begin
            r_rd_idx <= r_cnt[AW-1:0];
        end
        if (r_rd_vld && !i_cmd.cscan) begin
            if (id_match && !r_match_found) begin
                r_match_slot <= r_rd_idx;
            end
            if (!ent_valid && !r_free_found) begin
                r_free_slot <= r_rd_idx;
            end
            if (price_match && (r_req.op == sott_pkg::OP_TICK)) begin
                r_best_slot <= r_rd_idx;
                r_best      <= rd_entry;
            end
        end
        if (i_cmd.commit) begin
            r_prod <= 24'(r_best.slip) * 24'(r_tick);
        end
        if (i_cmd.commit && drop) begin
            r_res.status      <= sott_pkg::STATUS_DROPPED;
            r_res.fired_id    <= r_req.order_id;
            r_res.fired_price <= r_req.order_price;
            r_res.fired_sell  <= r_req.is_sell;
        end else if (i_cmd.fire) begin
            r_res.status      <= sott_pkg::STATUS_FIRED;
            r_res.fired_id    <= r_best.id;
            r_res.fired_price <= sat_price;
            r_res.fired_sell  <= r_best.sell;
        end
    end

    assign o_sts.scan_done = (r_cnt == LAST_CNT) && !r_rd_vld;
    assign o_sts.hit       = r_hit;
    assign o_res           = r_res;
    assign o_res_strobe    = r_stb;

    // The entry memory is never written while a scan reads it.
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_go |-> !wr_en)
        else $error("entry write during a scan");

    // A triggered order is gone from the table once the commit is done.
    a_fired_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_hit) |=> !r_valid[r_best_slot])
        else $error("triggered order still valid after commit");

endmodule

FILE: hw/rtl/stop_order_trigger_table_unit.sv
// Top level of the stop order trigger table: controller, datapath and ports.
//
// The block holds up to ENTRIES pending stop orders with one-cancels-other
// pairing. A request is taken when start is high and busy is low. Every
// request reads the whole entry memory once, one entry a cycle through its
// single read port, then settles the last read and commits, so an add, a
// remove, an ignored code or a price tick that triggers nothing passes through
// S_SCAN and S_COMMIT while busy is high. A price tick that triggers an
// order reads the memory a second time to delete the counter order (S_CSCAN)
// and then builds the result (S_FIRE) before busy falls. A result (a fired
// order, or an add dropped because the table is full) appears on o_res for
// exactly one cycle with o_res_strobe high, in the cycle in which busy falls;
// the receiver cannot stall it, so it must take it in that cycle. tick_value
// is written through i_cfg_wr_en and i_cfg_wr_data; the user must do so only
// while the block is idle, as the block itself does not enforce it.
module stop_order_trigger_table_unit #(
    parameter int ENTRIES = sott_pkg::ENTRIES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic [15:0]    i_cfg_wr_data,
    input  logic           start,
    output logic           busy,
    input  sott_pkg::t_req i_req,
    output sott_pkg::t_res o_res,
    output logic           o_res_strobe
);

    sott_pkg::t_dp_cmd cmd;
    sott_pkg::t_dp_sts sts;

    // Sequencing of each request.
    sott_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Entry store, scan compares and result formation.
    sott_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (i_req),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_res         (o_res),
        .o_res_strobe  (o_res_strobe)
    );

endmodule
